@@ rtl/rgbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbd_pkg
// Shared widths, configuration codes and the command/status types that join
// the controller and the datapath of the RGB block-mean downsampler.
// ----------------------------------------------------------------------------
package rgbd_pkg;

    // Default sizing of the line store and of the block factors.
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_FACTOR = 16;

    // Pixel channel width.
    localparam int PIX_W = 8;

    // Configuration port and register widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int FACTOR_W   = 5;
    localparam int FWIDTH_W   = 10;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd2;

    // Register values after reset.
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd1;
    localparam logic [FWIDTH_W-1:0] FWIDTH_RST = 10'd512;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;    // restart counters and the reciprocal divider
        logic step;    // one bit of the reciprocal division
        logic accept;  // take the input word and read its column sum
        logic acc;     // add the pixel and write the column sum back
        logic mul;     // multiply the block sums by the reciprocal
        logic load;    // load the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic restart;   // a configuration register was written
        logic in_block;  // the current pixel lies in a whole block
        logic emit;      // the pixel in flight completes its block
        logic out_free;  // the output register can take a word
    } t_ctrl_sts;

endpackage

@@ rtl/rgbd_ram.sv @@
// ----------------------------------------------------------------------------
// rgbd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rgbd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rgbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rgbd_ctrl
// Controller of the downsampler: runs the reciprocal setup after reset and
// after each register write, then sequences each pixel of a whole block
// through read and accumulate, and the last pixel of a block on through multiply and output.
// ----------------------------------------------------------------------------
module rgbd_ctrl import rgbd_pkg::*; #(
    parameter int DIV_STEPS = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] ST_PREP = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_PREP: begin
                // First cycle loads the divider, the rest shift one bit each.
                if (r_cnt == '0) begin
                    o_cmd.init = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_block) begin
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_PREP;
                n_cnt   = '0;
            end
        endcase
        // A register write starts a new frame and a new reciprocal.
        if (i_sts.restart) begin
            n_state = ST_PREP;
            n_cnt   = '0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PREP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

@@ rtl/rgbd_dpath.sv @@
// ----------------------------------------------------------------------------
// rgbd_dpath
// Datapath of the downsampler: configuration registers, position counters,
// column-sum line store, reciprocal divider, block-mean multipliers and the
// output register.
// ----------------------------------------------------------------------------
module rgbd_dpath import rgbd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    parameter int AREA_W     = 9,
    parameter int SUM_W      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_sts             o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic                  o_row_end
);

    localparam int DIV_W  = SUM_W + AREA_W;
    localparam int PROD_W = SUM_W + DIV_W + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FW_W   = $clog2(MAX_WIDTH + 1);
    localparam int WW_W   = (FW_W > FWIDTH_W) ? FW_W : FWIDTH_W;
    localparam int FX_W   = $clog2(MAX_FACTOR + 1);
    localparam int FXW_W  = (FX_W > FACTOR_W) ? FX_W : FACTOR_W;
    localparam int FC_W   = $clog2(MAX_FACTOR);
    localparam int E_W    = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
    localparam int MEM_W  = 3 * SUM_W;

    // Configuration registers.
    logic [FACTOR_W-1:0] r_factor_x;
    logic [FACTOR_W-1:0] r_factor_y;
    logic [FWIDTH_W-1:0] r_frame_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_x    <= FACTOR_RST;
            r_factor_y    <= FACTOR_RST;
            r_frame_width <= FWIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FACTOR_X:    r_factor_x    <= i_cfg_data[FACTOR_W-1:0];
                CFG_FACTOR_Y:    r_factor_y    <= i_cfg_data[FACTOR_W-1:0];
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[FWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_sts.restart = i_cfg_we && ((i_cfg_index == CFG_FACTOR_X) ||
                                        (i_cfg_index == CFG_FACTOR_Y) ||
                                        (i_cfg_index == CFG_FRAME_WIDTH));

    // Effective factors and width: zero acts as one, large values saturate.
    logic [FXW_W-1:0] fx_wide;
    logic [FXW_W-1:0] fy_wide;
    logic [WW_W-1:0]  fw_wide;
    logic [FX_W-1:0]  fx_c;
    logic [FX_W-1:0]  fy_c;
    logic [FW_W-1:0]  fw_c;

    always_comb begin
        fx_wide = FXW_W'(r_factor_x);
        fy_wide = FXW_W'(r_factor_y);
        fw_wide = WW_W'(r_frame_width);
        if (r_factor_x == '0) begin
            fx_c = FX_W'(1);
        end else if (fx_wide > FXW_W'(MAX_FACTOR)) begin
            fx_c = FX_W'(MAX_FACTOR);
        end else begin
            fx_c = fx_wide[FX_W-1:0];
        end
        if (r_factor_y == '0) begin
            fy_c = FX_W'(1);
        end else if (fy_wide > FXW_W'(MAX_FACTOR)) begin
            fy_c = FX_W'(MAX_FACTOR);
        end else begin
            fy_c = fy_wide[FX_W-1:0];
        end
        if (r_frame_width == '0) begin
            fw_c = FW_W'(1);
        end else if (fw_wide > WW_W'(MAX_WIDTH)) begin
            fw_c = FW_W'(MAX_WIDTH);
        end else begin
            fw_c = fw_wide[FW_W-1:0];
        end
    end

    // Block area, registered ahead of the divider.
    logic [AREA_W-1:0] r_area;

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(fx_c) * AREA_W'(fy_c);
    end

    // Reciprocal: ceil(2^DIV_W / area) as floor((2^DIV_W - 1) / area) + 1,
    // one quotient bit per step.
    logic [AREA_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W:0]    r_recip;
    logic [AREA_W:0]   rem_sh;
    logic              rem_ge;
    logic [AREA_W:0]   rem_nx;
    logic [DIV_W-1:0]  quo_nx;

    always_comb begin
        rem_sh = {r_rem, 1'b1};
        rem_ge = (rem_sh >= {1'b0, r_area});
        rem_nx = rem_ge ? (rem_sh - {1'b0, r_area}) : rem_sh;
        quo_nx = {r_quo[DIV_W-2:0], rem_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.step) begin
            r_rem   <= rem_nx[AREA_W-1:0];
            r_quo   <= quo_nx;
            r_recip <= {1'b0, quo_nx} + 1'b1;
        end
    end

    // Position counters.
    logic [COL_W-1:0] r_pcol;
    logic [COL_W-1:0] n_pcol;
    logic [FC_W-1:0]  r_cib;
    logic [FC_W-1:0]  n_cib;
    logic [FC_W-1:0]  r_row;
    logic [FC_W-1:0]  n_row;
    logic [COL_W:0]   r_col;
    logic [COL_W:0]   n_col;
    logic [E_W-1:0]   r_bend;
    logic [E_W-1:0]   n_bend;
    logic [E_W-1:0]   fw_e;
    logic [E_W-1:0]   fx_e;
    logic             in_block;
    logic             cib_last;
    logic             row_last;
    logic             row_wrap;

    always_comb begin
        fw_e     = E_W'(fw_c);
        fx_e     = E_W'(fx_c);
        // The block ends at r_bend; it is whole if it ends within the row.
        in_block = (r_bend <= fw_e);
        cib_last = ((FX_W'(r_cib) + FX_W'(1)) >= fx_c);
        row_last = ((FX_W'(r_row) + FX_W'(1)) >= fy_c);
        row_wrap = ((E_W'(r_pcol) + E_W'(1)) >= fw_e);
    end

    always_comb begin
        n_pcol = r_pcol;
        n_cib  = r_cib;
        n_row  = r_row;
        n_col  = r_col;
        n_bend = r_bend;
        if (i_cmd.init) begin
            n_pcol = '0;
            n_cib  = '0;
            n_row  = '0;
            n_col  = '0;
            n_bend = fx_e;
        end else if (i_cmd.accept) begin
            if (in_block) begin
                if (cib_last) begin
                    n_cib  = '0;
                    n_col  = r_col + 1'b1;
                    n_bend = r_bend + fx_e;
                end else begin
                    n_cib = r_cib + 1'b1;
                end
            end
            if (row_wrap) begin
                n_pcol = '0;
                n_cib  = '0;
                n_col  = '0;
                n_bend = fx_e;
                n_row  = row_last ? '0 : (r_row + 1'b1);
            end else begin
                n_pcol = r_pcol + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol <= '0;
            r_cib  <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_bend <= '0;
        end else begin
            r_pcol <= n_pcol;
            r_cib  <= n_cib;
            r_row  <= n_row;
            r_col  <= n_col;
            r_bend <= n_bend;
        end
    end

    assign o_sts.in_block = in_block;

    // Pixel in flight. The first pixel of a block in the first row of a
    // group starts a fresh sum, so the line store never needs clearing.
    logic [PIX_W-1:0] r_pix_r;
    logic [PIX_W-1:0] r_pix_g;
    logic [PIX_W-1:0] r_pix_b;
    logic [COL_W-1:0] r_addr;
    logic             r_fresh;
    logic             r_emit;
    logic             r_row_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix_r   <= i_red_in;
            r_pix_g   <= i_green_in;
            r_pix_b   <= i_blue_in;
            r_addr    <= r_col[COL_W-1:0];
            r_fresh   <= (r_row == '0) && (r_cib == '0);
            r_emit    <= cib_last && row_last;
            r_row_end <= ((r_bend + fx_e) > fw_e);
        end
    end

    assign o_sts.emit = r_emit;

    // Column-sum line store, read on accept and written back in the next cycle.
    logic [MEM_W-1:0] mem_rdata;
    logic [MEM_W-1:0] mem_wdata;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;

    always_comb begin
        sum_r = (r_fresh ? '0 : mem_rdata[3*SUM_W-1 -: SUM_W]) + SUM_W'(r_pix_r);
        sum_g = (r_fresh ? '0 : mem_rdata[2*SUM_W-1 -: SUM_W]) + SUM_W'(r_pix_g);
        sum_b = (r_fresh ? '0 : mem_rdata[SUM_W-1:0]) + SUM_W'(r_pix_b);
        mem_wdata = {sum_r, sum_g, sum_b};
    end

    rgbd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.accept && in_block),
        .i_raddr (r_col[COL_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // Finished block sums, then the mean by reciprocal multiply.
    logic [SUM_W-1:0]  r_sum_r;
    logic [SUM_W-1:0]  r_sum_g;
    logic [SUM_W-1:0]  r_sum_b;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_emit) begin
            r_sum_r <= sum_r;
            r_sum_g <= sum_g;
            r_sum_b <= sum_b;
        end
        if (i_cmd.mul) begin
            r_prod_r <= r_sum_r * r_recip;
            r_prod_g <= r_sum_g * r_recip;
            r_prod_b <= r_sum_b * r_recip;
        end
    end

    // Output register.
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_r;
    logic [PIX_W-1:0] r_out_g;
    logic [PIX_W-1:0] r_out_b;
    logic             r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_r   <= r_prod_r[DIV_W +: PIX_W];
            r_out_g   <= r_prod_g[DIV_W +: PIX_W];
            r_out_b   <= r_prod_b[DIV_W +: PIX_W];
            r_out_end <= r_row_end;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_red_out      = r_out_r;
    assign o_green_out    = r_out_g;
    assign o_blue_out     = r_out_b;
    assign o_row_end      = r_out_end;

endmodule

@@ rtl/rgb_block_mean_downsampler.sv @@
// ----------------------------------------------------------------------------
// rgb_block_mean_downsampler
// Box-filter downsampler: averages each factor_x by factor_y block of an RGB
// raster stream into one output pixel, with per-column sums in a line store.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+----------------------------------
//   in       | i_in_valid / o_in_stall    | i_red_in, i_green_in, i_blue_in
//   out      | o_out_valid / i_out_stall  | o_red_out, o_green_out,
//            |                            | o_blue_out, o_row_end
//   config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A pixel outside every whole block is taken in the idle state alone, a pixel
// inside a block also passes the accumulate state (read and write back of its
// column sum in the line store), and the last pixel of a block goes on through
// the multiply and output states (reciprocal multiply, output load), waiting
// there while the output register stays stalled.
// After reset and after each register write, the block computes the area
// reciprocal one bit a cycle and accepts no word until it is done.
// A waiting output word holds off input only once the next block mean is
// ready to load.
// ----------------------------------------------------------------------------
module rgb_block_mean_downsampler import rgbd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic                  o_row_end
);

    // Sum and reciprocal widths follow from the largest block.
    localparam int AREA_W    = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int SUM_W     = $clog2(MAX_FACTOR * MAX_FACTOR * ((1 << PIX_W) - 1) + 1);
    localparam int DIV_STEPS = SUM_W + AREA_W;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    rgbd_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rgbd_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .AREA_W     (AREA_W),
        .SUM_W      (SUM_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end)
    );

endmodule

@@ rtl/rgbd_checker.sv @@
// ----------------------------------------------------------------------------
// rgbd_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module rgbd_checker import rgbd_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [PIX_W-1:0]      o_red_out,
    input logic [PIX_W-1:0]      o_green_out,
    input logic [PIX_W-1:0]      o_blue_out,
    input logic                  o_row_end
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red_out) &&
        $stable(o_green_out) && $stable(o_blue_out) && $stable(o_row_end))
        else $error("stalled output word changed");

    // Reset empties the output and holds off input during setup.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output or input open right after reset");

    // A register write starts the reciprocal setup, which blocks input.
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && ((i_cfg_index == CFG_FACTOR_X) ||
                     (i_cfg_index == CFG_FACTOR_Y) ||
                     (i_cfg_index == CFG_FRAME_WIDTH)) |=> o_in_stall)
        else $error("input accepted during setup after a register write");

    // A new output word is loaded only while the input side is held off.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word appeared without a block in flight");

endmodule

bind rgb_block_mean_downsampler rgbd_checker u_rgbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_row_end   (o_row_end)
);

@@ tb/rgb_block_mean_downsampler_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_block_mean_downsampler_tb
// Self-checking bench for the RGB block-mean downsampler. Pixel words go in
// through the valid/stall channel. An in-bench predictor of the box filter
// works out the expected block means. A checker compares every output word,
// in order, against them while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rgb_block_mean_downsampler_tb;
    import rgbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index past the end of the register list; a write must do nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    localparam int TOTAL_PIXELS  = 1850;
    // Covers an in-flight pixel plus the reciprocal setup after a write.
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
    } t_mean_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_red_in;
    logic [PIX_W-1:0]      i_green_in;
    logic [PIX_W-1:0]      i_blue_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic                  o_row_end;

    // Predictor state: registers, line store of column sums and position counters.
    logic [FACTOR_W-1:0] factor_x_reg;
    logic [FACTOR_W-1:0] factor_y_reg;
    logic [FWIDTH_W-1:0] frame_width_reg;
    int unsigned         red_sum   [DEF_MAX_WIDTH];
    int unsigned         green_sum [DEF_MAX_WIDTH];
    int unsigned         blue_sum  [DEF_MAX_WIDTH];
    int unsigned         pix_col;
    int unsigned         col_in_blk;
    int unsigned         row_in_grp;

    t_mean_pixel expected_means[$];

    int  mismatches   = 0;
    int  pixels_sent  = 0;
    int  means_seen   = 0;
    int  cfg_writes   = 0;
    int  phases       = 0;
    int  stall_hold   = 0;
    bit  no_gaps      = 1'b0;

    rgb_block_mean_downsampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // A new frame starts: empty line store, counters at zero.
    function automatic void restart_frame_model();
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            red_sum[i]   = 0;
            green_sum[i] = 0;
            blue_sum[i]  = 0;
        end
        pix_col    = 0;
        col_in_blk = 0;
        row_in_grp = 0;
    endfunction

    // Zero acts as one and anything above the ceiling acts as the ceiling.
    function automatic int unsigned clamp_setting(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Accumulate one accepted pixel and queue the block mean it completes, if any.
    function automatic void predict_block_mean(input logic [PIX_W-1:0] r, g, b);
        int unsigned fx, fy, fw, blocks, col, area;
        t_mean_pixel m;
        fx     = clamp_setting(factor_x_reg, DEF_MAX_FACTOR);
        fy     = clamp_setting(factor_y_reg, DEF_MAX_FACTOR);
        fw     = clamp_setting(frame_width_reg, DEF_MAX_WIDTH);
        blocks = fw / fx;
        // Pixels past the last whole block only advance the column.
        if (pix_col < blocks * fx) begin
            col = pix_col / fx;
            red_sum[col]   += r;
            green_sum[col] += g;
            blue_sum[col]  += b;
            if (col_in_blk + 1 >= fx && row_in_grp + 1 >= fy) begin
                area      = fx * fy;
                m.red     = PIX_W'(red_sum[col] / area);
                m.green   = PIX_W'(green_sum[col] / area);
                m.blue    = PIX_W'(blue_sum[col] / area);
                m.row_end = (col + 1 == blocks);
                expected_means.push_back(m);
                red_sum[col]   = 0;
                green_sum[col] = 0;
                blue_sum[col]  = 0;
            end
            col_in_blk++;
            if (col_in_blk >= fx) col_in_blk = 0;
        end
        pix_col++;
        if (pix_col >= fw) begin
            pix_col    = 0;
            col_in_blk = 0;
            row_in_grp++;
            if (row_in_grp >= fy) row_in_grp = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Send one pixel word and hold it until it is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
        int gap;
        i_in_valid <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_block_mean(r, g, b);
        pixels_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_pixels(input int count);
        for (int k = 0; k < count; k++) send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // Stop sending and wait for every pending block mean.
    task automatic wait_for_means();
        i_in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_means();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_FACTOR_X: begin
                factor_x_reg = data[FACTOR_W-1:0];
                restart_frame_model();
            end
            CFG_FACTOR_Y: begin
                factor_y_reg = data[FACTOR_W-1:0];
                restart_frame_model();
            end
            CFG_FRAME_WIDTH: begin
                frame_width_reg = data[FWIDTH_W-1:0];
                restart_frame_model();
            end
            default: begin
                // No register here, so the frame carries on.
            end
        endcase
    endtask

    // Factor setting with junk in the unused upper bits of the data word.
    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        int r;
        logic [FACTOR_W-1:0] f;
        r = $urandom_range(0, 99);
        if (r < 8) f = '0;
        else if (r < 18) f = FACTOR_W'($urandom_range(17, 31));
        else if (r < 25) f = FACTOR_W'(16);
        else f = FACTOR_W'($urandom_range(1, 8));
        return {5'($urandom), f};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return CFG_DATA_W'($urandom_range(513, 1023));
        if (r < 15) return CFG_DATA_W'(512);
        if (r < 25) return CFG_DATA_W'($urandom_range(65, 511));
        return CFG_DATA_W'($urandom_range(1, 64));
    endfunction

    // Output side: random stall runs, mostly short, a few long, with quiet stretches.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!i_out_stall && $urandom_range(0, 99) < 35) begin
            i_out_stall <= 1'b1;
            stall_hold  <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
        end else begin
            i_out_stall <= 1'b0;
            stall_hold  <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                       : $urandom_range(20, 80);
        end
    end

    // Compare each accepted output word with the oldest pending block mean.
    always @(posedge i_clk) begin : check_means
        t_mean_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_means.size() == 0) begin
                report_mismatch("unexpected output word", 1, 0);
            end else begin
                want = expected_means.pop_front();
                means_seen++;
                if (o_red_out !== want.red) report_mismatch("red_out", o_red_out, want.red);
                if (o_green_out !== want.green)
                    report_mismatch("green_out", o_green_out, want.green);
                if (o_blue_out !== want.blue) report_mismatch("blue_out", o_blue_out, want.blue);
                if (o_row_end !== want.row_end)
                    report_mismatch("row_end", o_row_end, want.row_end);
            end
        end
    end

    // Settings after reset: every pixel is its own block, so every word echoes.
    task automatic test_reset_settings();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hA5, 8'h5A, 8'h0F);
    endtask

    // Zero factors act as one; a two pixel row flags its second word as row end.
    task automatic test_zero_factors();
        cfg_write(CFG_FACTOR_X, '0);
        cfg_write(CFG_FACTOR_Y, '0);
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
        send_pixel(8'h01, 8'h80, 8'hFE);
        send_pixel(8'hFE, 8'h7F, 8'h01);
    endtask

    // A zero frame width acts as a one pixel row.
    task automatic test_zero_width();
        cfg_write(CFG_FRAME_WIDTH, '0);
        send_pixel(8'h12, 8'h34, 8'h56);
        send_pixel(8'hED, 8'hCB, 8'hA9);
    endtask

    // Odd width leaves a partial block; a write to an unused index keeps the frame.
    task automatic test_partial_block();
        cfg_write(CFG_FACTOR_X, CFG_DATA_W'(2));
        cfg_write(CFG_FACTOR_Y, CFG_DATA_W'(1));
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
        send_pixel(8'd10, 8'd20, 8'd30);
        cfg_write(CFG_NO_REG, '1);
        send_pixel(8'd11, 8'd21, 8'd31);
        send_pixel(8'd99, 8'd99, 8'd99);
    endtask

    // A block wider than the row never completes.
    task automatic test_block_wider_than_row();
        cfg_write(CFG_FACTOR_X, CFG_DATA_W'(5));
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(4));
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
    endtask

    // A factor above the ceiling acts as 16; all-ones pixels give the largest sums for this block.
    task automatic test_oversized_factor();
        cfg_write(CFG_FACTOR_X, CFG_DATA_W'(17));
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(16));
        for (int k = 0; k < 16; k++) send_pixel(8'hFF, 8'hFF, 8'hFF);
    endtask

    // Largest block area, and the widest row with an oversized width setting.
    task automatic test_extreme_settings();
        cfg_write(CFG_FACTOR_X, CFG_DATA_W'(16));
        cfg_write(CFG_FACTOR_Y, CFG_DATA_W'(16));
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(16));
        send_random_pixels(256);
        cfg_write(CFG_FACTOR_X, CFG_DATA_W'(31));
        cfg_write(CFG_FACTOR_Y, CFG_DATA_W'(1));
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(1023));
        send_random_pixels(520);
        phases += 2;
    endtask

    // Random settings per phase, each running one to three row groups or a cut frame.
    task automatic test_random_frames();
        int n, drain_at, fy, fw;
        bit wrote;
        while (pixels_sent < TOTAL_PIXELS) begin
            wrote = 1'b0;
            if ($urandom_range(0, 99) < 70) begin
                cfg_write(CFG_FACTOR_X, pick_factor());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 99) < 70) begin
                cfg_write(CFG_FACTOR_Y, pick_factor());
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 99) < 50) cfg_write(CFG_FRAME_WIDTH, pick_width());
            if ($urandom_range(0, 99) < 5) cfg_write(CFG_NO_REG, CFG_DATA_W'($urandom));
            fy = clamp_setting(factor_y_reg, DEF_MAX_FACTOR);
            fw = clamp_setting(frame_width_reg, DEF_MAX_WIDTH);
            n = fw * fy * $urandom_range(1, 3);
            if (n > 400) n = $urandom_range(100, 400);
            else if ($urandom_range(0, 99) < 20) n = $urandom_range(1, n);
            // The last phase stops at the planned pixel count.
            if (n > TOTAL_PIXELS - pixels_sent) n = TOTAL_PIXELS - pixels_sent;
            no_gaps  = ($urandom_range(0, 99) < 25);
            drain_at = ($urandom_range(0, 99) < 30) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++) begin
                // Hold the sender off until every pending mean has come out.
                if (k == drain_at) wait_for_means();
                send_pixel(pick_channel(), pick_channel(), pick_channel());
            end
            phases++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin : run
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FACTOR_X;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_red_in    <= '0;
        i_green_in  <= '0;
        i_blue_in   <= '0;
        i_out_stall <= 1'b0;
        factor_x_reg    = FACTOR_RST;
        factor_y_reg    = FACTOR_RST;
        frame_width_reg = FWIDTH_RST;
        restart_frame_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_zero_factors();
        test_zero_width();
        test_partial_block();
        test_block_wider_than_row();
        test_oversized_factor();
        test_extreme_settings();
        test_random_frames();

        wait_for_means();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixel words over %0d random phases and %0d register writes.",
                 pixels_sent, phases, cfg_writes);
        $display("Compared %0d block means; %0d mismatches.", means_seen, mismatches);
        if (mismatches == 0) begin
            $display("[rgb_block_mean_downsampler] OK");
        end else begin
            $display("[rgb_block_mean_downsampler] ERROR");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d block means still pending.", expected_means.size());
        $display("[rgb_block_mean_downsampler] ERROR");
        $finish;
    end

endmodule

@@ rgb_block_mean_downsampler.f @@
rtl/rgbd_pkg.sv
rtl/rgbd_ram.sv
rtl/rgbd_ctrl.sv
rtl/rgbd_dpath.sv
rtl/rgb_block_mean_downsampler.sv
rtl/rgbd_checker.sv
tb/rgb_block_mean_downsampler_tb.sv
